// ===== src/ryc_pkg.sv =====
// Shared types, configuration codes and conversion constants for the RGB/YUV converter.
package ryc_pkg;

  typedef struct packed {
    logic [7:0] red_or_luma;
    logic [7:0] green_or_cb;
    logic [7:0] blue_or_cr;
  } ryc_in_t;

  typedef struct packed {
    logic [7:0] luma_or_red;
    logic [7:0] cb_or_green;
    logic [7:0] cr_or_blue;
  } ryc_out_t;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CAP_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_CAP = 1'b1;

  localparam logic DIR_RGB_TO_YUV = 1'b0;
  localparam logic DIR_YUV_TO_RGB = 1'b1;

  localparam logic [CAP_W-1:0] CAP_MIN = 9'd2;
  localparam logic [CAP_W-1:0] CAP_MAX = 9'd256;

  localparam logic [16:0] KY_R = 17'd77;
  localparam logic [16:0] KY_G = 17'd150;
  localparam logic [16:0] KY_B = 17'd29;

  localparam logic signed [17:0] KC_MAIN = 18'sd128;
  localparam logic signed [17:0] KU_R = 18'sd43;
  localparam logic signed [17:0] KU_G = 18'sd85;
  localparam logic signed [17:0] KV_G = 18'sd107;
  localparam logic signed [17:0] KV_B = 18'sd21;

  localparam logic [16:0] KR_V = 17'd359;
  localparam logic [16:0] KG_U = 17'd88;
  localparam logic [16:0] KG_V = 17'd183;
  localparam logic [16:0] KB_U = 17'd454;

  localparam logic signed [10:0] OFF_R = 11'sd179;
  localparam logic signed [10:0] OFF_G = 11'sd135;
  localparam logic signed [10:0] OFF_B = 11'sd227;

endpackage

// ===== src/ryc_convert.sv =====
// Combinational colour-space arithmetic and clamping for one pixel in either direction.
module ryc_convert (
  input  ryc_pkg::ryc_in_t             pix_in,
  input  logic                         dir,
  input  logic [ryc_pkg::CAP_W-1:0]    cap,
  output ryc_pkg::ryc_out_t            pix_out
);

  logic [16:0]        a_u;
  logic [16:0]        b_u;
  logic [16:0]        c_u;
  logic signed [17:0] a_s;
  logic signed [17:0] b_s;
  logic signed [17:0] c_s;

  logic [16:0]        y_sum;
  logic signed [17:0] u_sum;
  logic signed [17:0] v_sum;
  logic [7:0]         half;
  logic signed [10:0] y_full;
  logic signed [10:0] u_full;
  logic signed [10:0] v_full;

  logic [16:0]        r_prod;
  logic [16:0]        gu_prod;
  logic [16:0]        gv_prod;
  logic [16:0]        b_prod;
  logic signed [10:0] r_full;
  logic signed [10:0] g_full;
  logic signed [10:0] b_full;

  logic [8:0]         cap_m1;

  function automatic logic [7:0] clamp_level(input logic signed [10:0] v,
                                             input logic [8:0] lim);
    logic [7:0] res;
    if (v > $signed({2'b00, lim})) begin
      res = lim[7:0];
    end else if (v < 11'sd0) begin
      res = 8'd0;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  always_comb begin
    a_u = {9'd0, pix_in.red_or_luma};
    b_u = {9'd0, pix_in.green_or_cb};
    c_u = {9'd0, pix_in.blue_or_cr};
    a_s = $signed({10'd0, pix_in.red_or_luma});
    b_s = $signed({10'd0, pix_in.green_or_cb});
    c_s = $signed({10'd0, pix_in.blue_or_cr});

    half = cap[8:1];
    y_sum = a_u * ryc_pkg::KY_R + b_u * ryc_pkg::KY_G + c_u * ryc_pkg::KY_B;
    u_sum = ryc_pkg::KC_MAIN * c_s - ryc_pkg::KU_R * a_s - ryc_pkg::KU_G * b_s;
    v_sum = ryc_pkg::KC_MAIN * a_s - ryc_pkg::KV_G * b_s - ryc_pkg::KV_B * c_s;
    y_full = $signed({2'b00, y_sum[16:8]});
    u_full = $signed({u_sum[17], u_sum[17:8]}) + $signed({3'b000, half});
    v_full = $signed({v_sum[17], v_sum[17:8]}) + $signed({3'b000, half});

    r_prod = c_u * ryc_pkg::KR_V;
    gu_prod = b_u * ryc_pkg::KG_U;
    gv_prod = c_u * ryc_pkg::KG_V;
    b_prod = b_u * ryc_pkg::KB_U;
    r_full = $signed({3'b000, pix_in.red_or_luma}) + $signed({2'b00, r_prod[16:8]})
             - ryc_pkg::OFF_R;
    g_full = $signed({3'b000, pix_in.red_or_luma}) + ryc_pkg::OFF_G
             - ($signed({2'b00, gu_prod[16:8]}) + $signed({2'b00, gv_prod[16:8]}));
    b_full = $signed({3'b000, pix_in.red_or_luma}) + $signed({2'b00, b_prod[16:8]})
             - ryc_pkg::OFF_B;

    cap_m1 = cap - 9'd1;
    if (dir == ryc_pkg::DIR_RGB_TO_YUV) begin
      pix_out.luma_or_red = clamp_level(y_full, cap_m1);
      pix_out.cb_or_green = clamp_level(u_full, cap_m1);
      pix_out.cr_or_blue  = clamp_level(v_full, cap_m1);
    end else begin
      pix_out.luma_or_red = clamp_level(r_full, cap_m1);
      pix_out.cb_or_green = clamp_level(g_full, cap_m1);
      pix_out.cr_or_blue  = clamp_level(b_full, cap_m1);
    end
  end

endmodule

// ===== src/rgb_yuv_color_converter.sv =====
// Top level of the RGB/YUV converter: configuration registers, input and result registers.
// The converter accepts one pixel item in every clock cycle and busy is never raised.
// Each result appears on out_pixel with out_valid high for exactly one cycle: the item is
// held in the input register while the conversion logic works on it, and its result is then
// held in the result register. The receiver cannot stall the results. Configuration writes
// take effect at once and should only be made while no item is in flight.
module rgb_yuv_color_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ryc_pkg::ryc_in_t                  in_pixel,
  output logic                              out_valid,
  output ryc_pkg::ryc_out_t                 out_pixel,
  input  logic                              cfg_we,
  input  logic [ryc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ryc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                          dir_r;
  logic                          dir_nxt;
  logic [ryc_pkg::CAP_W-1:0]     cap_r;
  logic [ryc_pkg::CAP_W-1:0]     cap_nxt;
  logic                          in_vld_r;
  ryc_pkg::ryc_in_t              in_pix_r;
  logic                          out_vld_r;
  ryc_pkg::ryc_out_t             out_pix_r;
  ryc_pkg::ryc_out_t             conv_pix;

  always_comb begin
    dir_nxt = dir_r;
    cap_nxt = cap_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ryc_pkg::CFG_DIRECTION: begin
          dir_nxt = cfg_wdata[0];
        end
        ryc_pkg::CFG_LEVEL_CAP: begin
          if (cfg_wdata < ryc_pkg::CAP_MIN) begin
            cap_nxt = ryc_pkg::CAP_MIN;
          end else if (cfg_wdata > ryc_pkg::CAP_MAX) begin
            cap_nxt = ryc_pkg::CAP_MAX;
          end else begin
            cap_nxt = cfg_wdata;
          end
        end
        default: begin
          dir_nxt = dir_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= ryc_pkg::DIR_RGB_TO_YUV;
      cap_r     <= ryc_pkg::CAP_MAX;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      dir_r     <= dir_nxt;
      cap_r     <= cap_nxt;
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_pix_r <= in_pixel;
    end
    if (in_vld_r) begin
      out_pix_r <= conv_pix;
    end
  end

  ryc_convert u_convert (
    .pix_in  (in_pix_r),
    .dir     (dir_r),
    .cap     (cap_r),
    .pix_out (conv_pix)
  );

  assign busy      = 1'b0;
  assign out_valid = out_vld_r;
  assign out_pixel = out_pix_r;

endmodule

// ===== src/ryc_checker.sv =====
// Port-level checker for the RGB/YUV converter and its bind to the top level.
module ryc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input ryc_pkg::ryc_out_t                 out_pixel,
  input logic                              out_valid
);

  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("Converter raised busy.");

  a_item_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("Accepted item did not produce a result two cycles later.");

  a_result_has_item : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("Result appeared without an accepted item.");

  a_result_known : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_pixel))
    else $error("Result carries unknown bits.");

endmodule

bind rgb_yuv_color_converter ryc_checker u_ryc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_pixel (out_pixel),
  .out_valid (out_valid)
);

// ===== bench/rgb_yuv_color_converter_tb.sv =====
// Self-checking testbench for the RGB/YUV converter: directed table, random bursts, prediction.
`timescale 1ns / 100ps

module rgb_yuv_color_converter_tb;
  import ryc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 92;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic     dir;
    logic [8:0] cap;
    ryc_in_t  px;
    logic     known;
    ryc_out_t exp;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [0:21] = '{
    '{DIR_RGB_TO_YUV, 9'd256, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd128, 8'd128}},
    '{DIR_RGB_TO_YUV, 9'd256, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd128, 8'd128}},
    '{DIR_RGB_TO_YUV, 9'd256, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{DIR_RGB_TO_YUV, 9'd256, '{8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{DIR_RGB_TO_YUV, 9'd256, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
    '{DIR_RGB_TO_YUV, 9'd256, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
    '{DIR_RGB_TO_YUV, 9'd2, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd1, 8'd1}},
    '{DIR_RGB_TO_YUV, 9'd2, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{DIR_RGB_TO_YUV, 9'd0, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd1, 8'd1}},
    '{DIR_RGB_TO_YUV, 9'd1, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd1, 8'd1}},
    '{DIR_RGB_TO_YUV, 9'd511, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd128, 8'd128}},
    '{DIR_RGB_TO_YUV, 9'd257, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd128, 8'd128}},
    '{DIR_YUV_TO_RGB, 9'd256, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd135, 8'd0}},
    '{DIR_YUV_TO_RGB, 9'd256, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd121, 8'd255}},
    '{DIR_YUV_TO_RGB, 9'd256, '{8'd128, 8'd128, 8'd128}, 1'b0, '0},
    '{DIR_YUV_TO_RGB, 9'd256, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{DIR_YUV_TO_RGB, 9'd256, '{8'd0, 8'd255, 8'd255}, 1'b0, '0},
    '{DIR_YUV_TO_RGB, 9'd2, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{DIR_YUV_TO_RGB, 9'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{DIR_YUV_TO_RGB, 9'd511, '{8'd128, 8'd0, 8'd255}, 1'b0, '0},
    '{DIR_YUV_TO_RGB, 9'd100, '{8'd200, 8'd50, 8'd220}, 1'b0, '0},
    '{DIR_RGB_TO_YUV, 9'd100, '{8'd200, 8'd50, 8'd220}, 1'b0, '0}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ryc_in_t in_pixel = '0;
  logic out_valid;
  ryc_out_t out_pixel;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ryc_out_t expected_pixels [$];
  logic cur_dir = DIR_RGB_TO_YUV;
  logic [8:0] cur_cap = CAP_MAX;
  int mismatch_count = 0;
  int cycle_count = 0;

  rgb_yuv_color_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] clamp_level(int v, int cap);
    if (v > cap - 1) begin
      return 8'(cap - 1);
    end
    if (v < 0) begin
      return 8'd0;
    end
    return 8'(v);
  endfunction

  function automatic ryc_out_t convert_pixel(ryc_in_t px, logic dir, logic [8:0] cap_reg);
    int a;
    int b;
    int c;
    int cap;
    int half;
    int o0;
    int o1;
    int o2;
    ryc_out_t res;
    a = int'(px.red_or_luma);
    b = int'(px.green_or_cb);
    c = int'(px.blue_or_cr);
    cap = int'(cap_reg);
    if (cap < 2) begin
      cap = 2;
    end else if (cap > 256) begin
      cap = 256;
    end
    if (dir == DIR_RGB_TO_YUV) begin
      half = cap >> 1;
      o0 = (77 * a + 150 * b + 29 * c) >>> 8;
      o1 = ((128 * c - 43 * a - 85 * b) >>> 8) + half;
      o2 = ((128 * a - 107 * b - 21 * c) >>> 8) + half;
    end else begin
      o0 = a + ((359 * c) >>> 8) - 179;
      o1 = a + 135 - (((88 * b) >>> 8) + ((183 * c) >>> 8));
      o2 = a + ((454 * b) >>> 8) - 227;
    end
    res.luma_or_red = clamp_level(o0, cap);
    res.cb_or_green = clamp_level(o1, cap);
    res.cr_or_blue = clamp_level(o2, cap);
    return res;
  endfunction

  function automatic logic [7:0] random_level();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return 8'd0;
        1: return 8'd255;
        2: return 8'd1;
        default: return 8'd254;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    ryc_out_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result, luma_or_red", out_pixel.luma_or_red, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel.luma_or_red !== want.luma_or_red) begin
          report_mismatch("luma_or_red", out_pixel.luma_or_red, want.luma_or_red);
        end
        if (out_pixel.cb_or_green !== want.cb_or_green) begin
          report_mismatch("cb_or_green", out_pixel.cb_or_green, want.cb_or_green);
        end
        if (out_pixel.cr_or_blue !== want.cr_or_blue) begin
          report_mismatch("cr_or_blue", out_pixel.cr_or_blue, want.cr_or_blue);
        end
      end
    end
  end

  task automatic send_pixel(ryc_in_t px, logic known, ryc_out_t want);
    @(negedge clk);
    start <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    expected_pixels.push_back(known ? want : convert_pixel(px, cur_dir, cur_cap));
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic dir, logic [8:0] cap);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_wdata <= {8'($urandom), dir};
    @(negedge clk);
    cfg_index <= CFG_LEVEL_CAP;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_dir = dir;
    cur_cap = cap;
  endtask

  initial begin
    int remaining;
    int burst;
    logic [8:0] phase_cap;
    ryc_in_t px;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].dir != cur_dir || DIRECTED_ROWS[i].cap != cur_cap) begin
        apply_settings(DIRECTED_ROWS[i].dir, DIRECTED_ROWS[i].cap);
      end
      send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].exp);
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase >> 1)
        0: phase_cap = CAP_MAX;
        1: phase_cap = CAP_MIN;
        2: phase_cap = 9'd0;
        3: phase_cap = 9'd511;
        4: phase_cap = 9'($urandom_range(2, 256));
        default: phase_cap = 9'($urandom_range(0, 511));
      endcase
      apply_settings(phase[0] ? DIR_YUV_TO_RGB : DIR_RGB_TO_YUV, phase_cap);
      remaining = PHASE_ITEMS;
      while (remaining > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > remaining) begin
          burst = remaining;
        end
        repeat (burst) begin
          px.red_or_luma = random_level();
          px.green_or_cb = random_level();
          px.blue_or_cr = random_level();
          send_pixel(px, 1'b0, '0);
        end
        remaining -= burst;
        if ($urandom_range(0, 9) == 0) begin
          drain_results();
        end else if ($urandom_range(0, 2) != 0) begin
          hold_off($urandom_range(1, 7));
        end
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
